>>> hw/rtl/lwfs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the cosine table of the wall-following steering block.
package lwfs_pkg;

  // Range code for a beam with no return
  localparam logic [15:0] NO_RETURN = 16'hFFFF;

  // Scan geometry in hundredths of a degree
  localparam logic signed [16:0] ANGLE_START = -17'sd10000;
  localparam logic signed [16:0] ANGLE_END   = 17'sd10000;
  localparam logic [13:0] QUARTER_CDEG = 14'd9000;
  localparam logic [14:0] HALF_CDEG    = 15'd18000;
  localparam logic [13:0] ROM_STEP_CDEG = 14'd500;

  // Reciprocal multipliers: x/500 and y/125 without a divider
  localparam logic [13:0] RECIP500_IDX = 14'd8389;      // 2^22 / 500, rounded up
  localparam logic [19:0] RECIP500_Q   = 20'd536870;    // 2^28 / 500, rounded down
  localparam logic [25:0] RECIP125     = 26'd34359739;  // 2^32 / 125, rounded up
  localparam logic [19:0] INTERP_HALF  = 20'd250;
  localparam logic [19:0] INTERP_DIV   = 20'd500;

  // Final scaling: divide by 16384000 = 2^17 * 125, half away from zero
  localparam logic [22:0] ROUND_HALF = 23'd8192000;
  localparam logic [21:0] SAT_LIMIT  = 22'd4096000;    // 32768 * 125
  localparam logic signed [15:0] RATE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] RATE_MIN = 16'sh8000;
  localparam logic signed [31:0] COS_SCALE = 32'sd1000;

  // Configuration register indexes
  localparam logic [2:0] CFG_ANGLE_STEP  = 3'd0;
  localparam logic [2:0] CFG_WALL_REACH  = 3'd1;
  localparam logic [2:0] CFG_SETPOINT    = 3'd2;
  localparam logic [2:0] CFG_STEER_GAIN  = 3'd3;
  localparam logic [2:0] CFG_SPEED       = 3'd4;
  localparam logic [2:0] CFG_SEARCH_RATE = 3'd5;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_t;

  // Summary of one finished scan, passed from front end to back end
  typedef struct packed {
    logic [15:0]        near_mm;
    logic signed [15:0] angle;
    logic               seen;
    side_t              side;
  } scan_sum_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_COS1,
    BK_COS2,
    BK_COS3,
    BK_COS4,
    BK_TERM,
    BK_PROD,
    BK_MAG,
    BK_RND,
    BK_DIV,
    BK_OUT
  } back_state_t;

  // Q1.14 cosine, one entry every 5 degrees from 0 to 90
  function automatic logic [14:0] cos_rom(input logic [4:0] idx);
    logic [14:0] v;
    case (idx)
      5'd0:  v = 15'd16384;
      5'd1:  v = 15'd16322;
      5'd2:  v = 15'd16135;
      5'd3:  v = 15'd15826;
      5'd4:  v = 15'd15396;
      5'd5:  v = 15'd14849;
      5'd6:  v = 15'd14189;
      5'd7:  v = 15'd13421;
      5'd8:  v = 15'd12551;
      5'd9:  v = 15'd11585;
      5'd10: v = 15'd10531;
      5'd11: v = 15'd9397;
      5'd12: v = 15'd8192;
      5'd13: v = 15'd6924;
      5'd14: v = 15'd5604;
      5'd15: v = 15'd4241;
      5'd16: v = 15'd2845;
      5'd17: v = 15'd1428;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/lwfs_front.sv
`timescale 1ns / 1ps
// Sample front end: tracks beam angle, per-side minima and the side lock, emits scan summaries.
module lwfs_front #(
  parameter int MAX_BEAMS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_range_mm,
  input  logic                in_last_sample,
  input  logic [14:0]         angle_step_cdeg,
  input  logic [15:0]         wall_reach_mm,
  input  logic                q_full,
  output logic                q_push,
  output lwfs_pkg::scan_sum_t q_wdata
);
  import lwfs_pkg::*;

  localparam int IDX_W = $clog2(MAX_BEAMS + 1);

  logic [IDX_W-1:0]   beam_idx_r, beam_idx_nxt;
  logic signed [16:0] angle_r, angle_nxt;
  logic [15:0]        min_right_r, min_right_nxt;
  logic [15:0]        min_left_r, min_left_nxt;
  logic signed [15:0] ang_right_r, ang_right_nxt;
  logic signed [15:0] ang_left_r, ang_left_nxt;
  side_t              side_r, side_nxt;

  logic               accept;
  logic               in_span;
  logic               take_right, take_left;
  logic               left_wins;
  logic [15:0]        near_mm;
  logic signed [15:0] dist_ang;
  logic               seen;
  side_t              side_new;

  // Stall while the summary queue is full
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign in_span  = beam_idx_r < IDX_W'(MAX_BEAMS);

  // Minimum update for the side that the current beam falls on
  assign take_right = accept && in_span && (angle_r <= 17'sd0) &&
                      (in_range_mm < min_right_r) && (side_r != SIDE_LEFT);
  assign take_left  = accept && in_span && (angle_r > 17'sd0) && (angle_r <= ANGLE_END) &&
                      (in_range_mm < min_left_r) && (side_r != SIDE_RIGHT);

  assign min_right_nxt = take_right ? in_range_mm : min_right_r;
  assign ang_right_nxt = take_right ? angle_r[15:0] : ang_right_r;
  assign min_left_nxt  = take_left ? in_range_mm : min_left_r;
  assign ang_left_nxt  = take_left ? angle_r[15:0] : ang_left_r;

  // End-of-scan choice: left wins a tie
  assign left_wins = min_left_nxt <= min_right_nxt;
  assign near_mm   = left_wins ? min_left_nxt : min_right_nxt;
  assign dist_ang  = left_wins ? ang_left_nxt : ang_right_nxt;
  assign seen      = (near_mm != NO_RETURN) && (near_mm <= wall_reach_mm);

  always_comb begin
    side_new = side_r;
    if (seen && side_r == SIDE_NONE) begin
      side_new = left_wins ? SIDE_LEFT : SIDE_RIGHT;
    end
  end

  // Beam counter and angle accumulator; angle holds once past the span
  always_comb begin
    beam_idx_nxt = beam_idx_r;
    angle_nxt    = angle_r;
    side_nxt     = side_r;
    if (accept) begin
      if (in_last_sample) begin
        beam_idx_nxt = '0;
        angle_nxt    = ANGLE_START;
        side_nxt     = side_new;
      end else if (in_span) begin
        beam_idx_nxt = beam_idx_r + IDX_W'(1);
        if (angle_r <= ANGLE_END) begin
          angle_nxt = angle_r + $signed({2'b00, angle_step_cdeg});
        end
      end
    end
  end

  assign q_push          = accept && in_last_sample;
  assign q_wdata.near_mm = near_mm;
  assign q_wdata.angle   = dist_ang;
  assign q_wdata.seen    = seen;
  assign q_wdata.side    = side_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_idx_r  <= '0;
      angle_r     <= ANGLE_START;
      min_right_r <= NO_RETURN;
      min_left_r  <= NO_RETURN;
      ang_right_r <= '0;
      ang_left_r  <= '0;
      side_r      <= SIDE_NONE;
    end else begin
      beam_idx_r <= beam_idx_nxt;
      angle_r    <= angle_nxt;
      side_r     <= side_nxt;
      if (q_push) begin
        min_right_r <= NO_RETURN;
        min_left_r  <= NO_RETURN;
        ang_right_r <= '0;
        ang_left_r  <= '0;
      end else begin
        min_right_r <= min_right_nxt;
        min_left_r  <= min_left_nxt;
        ang_right_r <= ang_right_nxt;
        ang_left_r  <= ang_left_nxt;
      end
    end
  end

endmodule

>>> hw/rtl/lwfs_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of scan summaries between the front end and the back end.
module lwfs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lwfs_pkg::scan_sum_t wdata,
  output logic                full,
  input  logic                pop,
  output logic                rd_valid,
  output lwfs_pkg::scan_sum_t rdata
);
  import lwfs_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  scan_sum_t          entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full     = count_r == CNT_W'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rdata    = entry_r[rd_ptr_r];

  // Occupancy follows push and pop
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  // Store entry on push
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rd_valid)
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count did not advance on push");
`endif

endmodule

>>> hw/rtl/lwfs_back.sv
`timescale 1ns / 1ps
// Back end: cosine lookup, steering product, rounding, saturation and the result register.
module lwfs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  lwfs_pkg::scan_sum_t        q_rdata,
  output logic                       q_pop,
  input  logic [15:0]                setpoint_mm,
  input  logic [7:0]                 steer_gain,
  input  logic [11:0]                speed_mm_s,
  input  logic signed [15:0]         search_rate_mrad_s,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [11:0]                out_forward_speed_mm_s,
  output logic signed [15:0]         out_turn_rate_mrad_s,
  output logic                       out_wall_seen,
  output logic [1:0]                 out_locked_side
);
  import lwfs_pkg::*;

  back_state_t state_r, state_nxt;

  scan_sum_t          ent_r;
  logic [13:0]        afold_r, afold_nxt;
  logic               cneg_r, cneg_nxt;
  logic               czero_r, czero_nxt;
  logic [27:0]        iprod_r, iprod_nxt;
  logic [19:0]        x_r, x_nxt;
  logic [14:0]        lo_r, lo_nxt;
  logic [10:0]        qest_r, qest_nxt;
  logic signed [15:0] c_r, c_nxt;
  logic [19:0]        gs_r, gs_nxt;
  logic signed [31:0] term_r, term_nxt;
  logic signed [51:0] prod_r, prod_nxt;
  logic               neg_r;
  logic [50:0]        mag_r, mag_nxt;
  logic               sat_r, sat_nxt;
  logic [21:0]        ylo_r, ylo_nxt;
  logic [14:0]        q_r, q_nxt;

  logic               out_valid_r;
  logic [11:0]        out_speed_r;
  logic signed [15:0] out_rate_r, rate_nxt;
  logic               out_seen_r;
  logic [1:0]         out_side_r;

  logic               out_free;
  logic               out_load;

  // Intermediate values of the datapath steps
  logic [15:0]        abs_ang;
  logic [4:0]         idx;
  logic [8:0]         frac;
  logic [14:0]        diff_full;
  logic [10:0]        diff;
  logic [39:0]        qprod;
  logic [19:0]        rem;
  logic [10:0]        qfix;
  logic [14:0]        c_mag;
  logic signed [16:0] err;
  logic [51:0]        rsum;
  logic [34:0]        y;
  logic [47:0]        qdiv;
  logic [15:0]        q_ext;
  logic               neg_fin;

  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid) state_nxt = q_rdata.seen ? BK_COS1 : BK_OUT;
      BK_COS1: state_nxt = BK_COS2;
      BK_COS2: state_nxt = BK_COS3;
      BK_COS3: state_nxt = BK_COS4;
      BK_COS4: state_nxt = BK_TERM;
      BK_TERM: state_nxt = BK_PROD;
      BK_PROD: state_nxt = BK_MAG;
      BK_MAG:  state_nxt = BK_RND;
      BK_RND:  state_nxt = BK_DIV;
      BK_DIV:  state_nxt = BK_OUT;
      BK_OUT:  if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop    = q_valid;
      BK_OUT:  out_load = out_free;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Fold the angle into 0..90 degrees and estimate the table index
  always_comb begin
    abs_ang   = ent_r.angle[15] ? 16'(-ent_r.angle) : ent_r.angle;
    cneg_nxt  = abs_ang[13:0] > QUARTER_CDEG;
    afold_nxt = cneg_nxt ? 14'(HALF_CDEG - {1'b0, abs_ang[13:0]}) : abs_ang[13:0];
    czero_nxt = afold_nxt >= QUARTER_CDEG;
    iprod_nxt = {14'd0, afold_nxt} * {14'd0, RECIP500_IDX};
  end

  // Table entries and interpolation numerator
  always_comb begin
    idx       = iprod_r[26:22];
    frac      = 9'(afold_r - 14'({9'd0, idx} * ROM_STEP_CDEG));
    lo_nxt    = cos_rom(idx);
    diff_full = lo_nxt - cos_rom(idx + 5'd1);
    diff      = diff_full[10:0];
    x_nxt     = {9'd0, diff} * {11'd0, frac} + INTERP_HALF;
  end

  // Quotient estimate of the interpolation drop, then one correction step
  always_comb begin
    qprod    = {20'd0, x_r} * {20'd0, RECIP500_Q};
    qest_nxt = qprod[38:28];
    rem      = x_r - 20'({9'd0, qest_r} * INTERP_DIV);
    qfix     = (rem >= INTERP_DIV) ? qest_r + 11'd1 : qest_r;
    c_mag    = lo_r - {4'd0, qfix};
    if (czero_r) begin
      c_nxt = '0;
    end else if (cneg_r) begin
      c_nxt = -$signed({1'b0, c_mag});
    end else begin
      c_nxt = $signed({1'b0, c_mag});
    end
    gs_nxt = {12'd0, steer_gain} * {8'd0, speed_mm_s};
  end

  // Error term, product, magnitude, rounding and the divide by 125
  always_comb begin
    err      = $signed({1'b0, ent_r.near_mm}) - $signed({1'b0, setpoint_mm});
    term_nxt = (c_r * COS_SCALE) - $signed({err[16], err, 14'd0});
    prod_nxt = term_r * $signed({1'b0, gs_r});
    mag_nxt  = prod_r[51] ? 51'(-prod_r) : prod_r[50:0];
    rsum     = {1'b0, mag_r} + {29'd0, ROUND_HALF};
    y        = rsum[51:17];
    sat_nxt  = y >= {13'd0, SAT_LIMIT};
    ylo_nxt  = y[21:0];
    qdiv     = {26'd0, ylo_r} * {22'd0, RECIP125};
    q_nxt    = qdiv[46:32];
  end

  // Signed, saturated turn rate, or the search rate with no wall
  always_comb begin
    q_ext   = {1'b0, q_r};
    neg_fin = neg_r ^ (ent_r.side != SIDE_RIGHT);
    if (!ent_r.seen) begin
      rate_nxt = search_rate_mrad_s;
    end else if (sat_r) begin
      rate_nxt = neg_fin ? RATE_MIN : RATE_MAX;
    end else if (neg_fin) begin
      rate_nxt = -$signed(q_ext);
    end else begin
      rate_nxt = $signed(q_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, one step per state
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: if (q_valid) ent_r <= q_rdata;
      BK_COS1: begin
        afold_r <= afold_nxt;
        cneg_r  <= cneg_nxt;
        czero_r <= czero_nxt;
        iprod_r <= iprod_nxt;
      end
      BK_COS2: begin
        x_r  <= x_nxt;
        lo_r <= lo_nxt;
      end
      BK_COS3: qest_r <= qest_nxt;
      BK_COS4: begin
        c_r  <= c_nxt;
        gs_r <= gs_nxt;
      end
      BK_TERM: term_r <= term_nxt;
      BK_PROD: prod_r <= prod_nxt;
      BK_MAG: begin
        mag_r <= mag_nxt;
        neg_r <= prod_r[51];
      end
      BK_RND: begin
        sat_r <= sat_nxt;
        ylo_r <= ylo_nxt;
      end
      BK_DIV: q_r <= q_nxt;
      default: ;
    endcase
    if (out_load) begin
      out_speed_r <= speed_mm_s;
      out_rate_r  <= rate_nxt;
      out_seen_r  <= ent_r.seen;
      out_side_r  <= ent_r.side;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_forward_speed_mm_s = out_speed_r;
  assign out_turn_rate_mrad_s   = out_rate_r;
  assign out_wall_seen          = out_seen_r;
  assign out_locked_side        = out_side_r;

endmodule

>>> hw/rtl/lidar_wall_follow_steer.sv
`timescale 1ns / 1ps
// A scan result passes from the scan queue through the back end's idle state, its cosine and
// multiply states (COS1 to DIV) and its output state into the result register; with no wall
// seen the COS1 to DIV states are skipped. Input takes one sample per cycle while the scan queue
// is not full; the back end takes one scan at a time, and the two-entry queue absorbs bursts.
// Reset (synchronous, rst_n low): control and configuration registers take their default values,
// no side is locked, per-scan minima read as no return; no clearing pass follows.
module lidar_wall_follow_steer #(
  parameter int MAX_BEAMS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_range_mm,
  input  logic               in_last_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_forward_speed_mm_s,
  output logic signed [15:0] out_turn_rate_mrad_s,
  output logic               out_wall_seen,
  output logic [1:0]         out_locked_side,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import lwfs_pkg::*;

  logic [14:0]        angle_step_r;
  logic [15:0]        wall_reach_r;
  logic [15:0]        setpoint_r;
  logic [7:0]         steer_gain_r;
  logic [11:0]        speed_r;
  logic signed [15:0] search_rate_r;

  logic      q_push, q_pop, q_full, q_valid;
  scan_sum_t q_wdata, q_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_step_r  <= 15'd100;
      wall_reach_r  <= 16'd30000;
      setpoint_r    <= 16'd1200;
      steer_gain_r  <= 8'd15;
      speed_r       <= 12'd400;
      search_rate_r <= 16'sd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANGLE_STEP:  angle_step_r  <= cfg_wdata[14:0];
        CFG_WALL_REACH:  wall_reach_r  <= cfg_wdata;
        CFG_SETPOINT:    setpoint_r    <= cfg_wdata;
        CFG_STEER_GAIN:  steer_gain_r  <= cfg_wdata[7:0];
        CFG_SPEED:       speed_r       <= cfg_wdata[11:0];
        CFG_SEARCH_RATE: search_rate_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  lwfs_front #(
    .MAX_BEAMS(MAX_BEAMS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_range_mm    (in_range_mm),
    .in_last_sample (in_last_sample),
    .angle_step_cdeg(angle_step_r),
    .wall_reach_mm  (wall_reach_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  lwfs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wdata   (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .rd_valid(q_valid),
    .rdata   (q_rdata)
  );

  lwfs_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_rdata               (q_rdata),
    .q_pop                 (q_pop),
    .setpoint_mm           (setpoint_r),
    .steer_gain            (steer_gain_r),
    .speed_mm_s            (speed_r),
    .search_rate_mrad_s    (search_rate_r),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_forward_speed_mm_s(out_forward_speed_mm_s),
    .out_turn_rate_mrad_s  (out_turn_rate_mrad_s),
    .out_wall_seen         (out_wall_seen),
    .out_locked_side       (out_locked_side)
  );

endmodule
